// ===== src/crrg_pkg.sv =====
// Shared constants, status structs and the xorshift step for the CMWC range generator.
// No dependencies; every other file depends on this package.
`default_nettype none
package crrg_pkg;

    localparam int WORD_W  = 32;
    localparam int CARRY_W = 30;
    localparam int CNT_W   = $clog2(WORD_W);

    localparam int LAG_DEFAULT = 8;

    localparam logic [CARRY_W-1:0] CMWC_MULT     = 30'd716514398;
    localparam logic [WORD_W-1:0]  CMWC_BASE     = 32'hffff_fffe;
    localparam logic [CARRY_W-1:0] CARRY_INIT    = 30'd362436;
    localparam logic [WORD_W-1:0]  SEED_ZERO_SUB = 32'd12345;
    localparam logic [WORD_W-1:0]  SEED_RESET    = 32'd987654321;

    // Status of a bit-serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    // Status of the lag table fill sequencer
    typedef struct packed {
        logic busy;
        logic wr_en;
    } t_fill_stat;

    // One xorshift 13/17/5 step
    function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] j);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        a = j ^ (j << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

endpackage
`default_nettype wire

// ===== src/crrg_if.sv =====
// Valid/ready stream interfaces for range requests and generated results.
// Depends on crrg_pkg for field widths.
`default_nettype none
interface crrg_in_if;
    import crrg_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] range_start;
    logic signed [WORD_W-1:0] range_end;

    modport source (output valid, output range_start, output range_end, input ready);
    modport sink   (input valid, input range_start, input range_end, output ready);
endinterface

interface crrg_out_if;
    import crrg_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] value;
    logic                     range_error;

    modport source (output valid, output value, output range_error, input ready);
    modport sink   (input valid, input value, input range_error, output ready);
endinterface
`default_nettype wire

// ===== src/crrg_refill.sv =====
// Lag table fill sequencer: writes one xorshift word per cycle from the seed.
// Depends on crrg_pkg.
`default_nettype none
module crrg_refill #(
    parameter int LAG = crrg_pkg::LAG_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [crrg_pkg::WORD_W-1:0]     i_seed,
    output crrg_pkg::t_fill_stat                 o_stat,
    output logic [$clog2(LAG)-1:0]               o_wr_addr,
    output logic [crrg_pkg::WORD_W-1:0]          o_wr_data
);
    import crrg_pkg::*;

    localparam int IDX_W = $clog2(LAG);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(LAG - 1);

    logic                r_busy;
    logic [IDX_W-1:0]    r_addr;
    logic [WORD_W-1:0]   r_j;
    logic [WORD_W-1:0]   n_j;

    assign n_j = xorshift(r_j);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_addr <= '0;
            r_j    <= SEED_RESET;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_addr <= '0;
            r_j    <= (i_seed == '0) ? SEED_ZERO_SUB : i_seed;
        end else if (r_busy) begin
            r_j <= n_j;
            if (r_addr == LAST) begin
                r_busy <= 1'b0;
            end else begin
                r_addr <= r_addr + 1'b1;
            end
        end
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.wr_en = r_busy && !i_start;
    assign o_wr_addr    = r_addr;
    assign o_wr_data    = n_j;

endmodule
`default_nettype wire

// ===== src/crrg_mul.sv =====
// Bit-serial multiply-add: product = CMWC_MULT * multiplicand + addend, one bit per cycle.
// Depends on crrg_pkg.
`default_nettype none
module crrg_mul (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [crrg_pkg::WORD_W-1:0]       i_mcand,
    input  wire logic [crrg_pkg::CARRY_W-1:0]      i_addend,
    output crrg_pkg::t_unit_stat                   o_stat,
    output logic [2*crrg_pkg::WORD_W-1:0]          o_prod
);
    import crrg_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_hi;
    logic [WORD_W-1:0] r_lo;
    logic [WORD_W:0]   n_sum;

    // add the constant when the current multiplicand bit is set
    assign n_sum = {1'b0, r_hi} + (r_lo[0] ? (WORD_W+1)'(CMWC_MULT) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNT_W'(WORD_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // the addend seeded into the high half lands at weight one after the last shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi <= WORD_W'(i_addend);
            r_lo <= i_mcand;
        end else if (r_busy) begin
            r_hi <= n_sum[WORD_W:1];
            r_lo <= {n_sum[0], r_lo[WORD_W-1:1]};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = {r_hi, r_lo};

endmodule
`default_nettype wire

// ===== src/crrg_mod.sv =====
// Bit-serial restoring remainder: dividend mod divisor, one dividend bit per cycle.
// Depends on crrg_pkg; the divisor must be nonzero.
`default_nettype none
module crrg_mod (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [crrg_pkg::WORD_W-1:0]   i_dividend,
    input  wire logic [crrg_pkg::WORD_W-1:0]   i_divisor,
    output crrg_pkg::t_unit_stat               o_stat,
    output logic [crrg_pkg::WORD_W-1:0]        o_rem
);
    import crrg_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_q;
    logic [WORD_W:0]   n_trial;
    logic [WORD_W:0]   n_diff;
    logic              n_ge;

    assign n_trial = {r_rem, r_q[WORD_W-1]};
    assign n_diff  = n_trial - {1'b0, i_divisor};
    assign n_ge    = (n_trial >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNT_W'(WORD_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            // remainder stays below the divisor, so the low word holds it
            r_rem <= n_ge ? n_diff[WORD_W-1:0] : n_trial[WORD_W-1:0];
            r_q   <= {r_q[WORD_W-2:0], 1'b0};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule
`default_nettype wire

// ===== src/cmwc_random_range_generator_top.sv =====
// Lag-LAG complementary multiply-with-carry generator returning a value in a signed range.
// Depends on crrg_pkg, crrg_if, crrg_refill, crrg_mul and crrg_mod.
//
// One request is handled at a time. A valid range passes from acceptance to the result
// register in these steps: the lag word is read at the accepting edge, then the bit-serial
// multiply-add is loaded, shifts through its bits and is seen to finish; the carry is folded
// and the table written back; the bit-serial remainder unit is loaded, shifts and is seen to
// finish; and the offset is added. A full 2^32 span skips the remainder; an empty or inverted
// range goes from acceptance straight to the result step without touching the state. The
// result step waits until the output register is free and the result then waits there, so a
// request can be accepted while the previous result is still pending. After reset and after
// every seed write the lag table is refilled one entry per cycle, during which no request is
// accepted.
`default_nettype none
module cmwc_random_range_generator_top #(
    parameter int LAG = crrg_pkg::LAG_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [crrg_pkg::WORD_W-1:0] i_cfg_wdata,
    crrg_in_if.sink                          i_req,
    crrg_out_if.source                       o_res
);
    import crrg_pkg::*;

    localparam int IDX_W = $clog2(LAG);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(LAG - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_FIX,
        S_MOD,
        S_OUT
    } t_state;

    t_state r_state;

    // lag table
    logic [WORD_W-1:0] r_mem [LAG];
    logic [WORD_W-1:0] r_rd_data;
    logic [IDX_W-1:0]  n_rd_addr;
    logic              n_wr_en;
    logic [IDX_W-1:0]  n_wr_addr;
    logic [WORD_W-1:0] n_wr_data;

    logic [IDX_W-1:0]   r_idx;
    logic [CARRY_W-1:0] r_carry;
    logic [WORD_W-1:0]  r_word;
    logic [WORD_W-1:0]  r_start;
    logic [WORD_W-1:0]  r_span;
    logic               r_full;
    logic               r_err;
    logic               r_mul_start;
    logic               r_mod_start;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_value;
    logic               r_out_err;

    t_fill_stat         fill_stat;
    logic [IDX_W-1:0]   fill_addr;
    logic [WORD_W-1:0]  fill_data;
    t_unit_stat         mul_stat;
    logic [2*WORD_W-1:0] mul_prod;
    t_unit_stat         mod_stat;
    logic [WORD_W-1:0]  mod_rem;

    logic               n_accept;
    logic               n_bad;
    logic [WORD_W-1:0]  n_span;
    logic [CARRY_W-1:0] n_carry_hi;
    logic [WORD_W:0]    n_fold;
    logic [WORD_W-1:0]  n_x;
    logic [CARRY_W-1:0] n_carry;
    logic [WORD_W-1:0]  n_w;
    logic               n_slot_free;

    crrg_refill #(
        .LAG (LAG)
    ) u_refill (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cfg_we),
        .i_seed    (i_cfg_wdata),
        .o_stat    (fill_stat),
        .o_wr_addr (fill_addr),
        .o_wr_data (fill_data)
    );

    crrg_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mul_start),
        .i_mcand  (r_rd_data),
        .i_addend (r_carry),
        .o_stat   (mul_stat),
        .o_prod   (mul_prod)
    );

    crrg_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_mod_start),
        .i_dividend (r_word),
        .i_divisor  (r_span),
        .o_stat     (mod_stat),
        .o_rem      (mod_rem)
    );

    assign i_req.ready = (r_state == S_IDLE) && !fill_stat.busy && !i_cfg_we;
    assign n_accept    = i_req.valid && i_req.ready;
    assign n_bad       = (i_req.range_end <= i_req.range_start);
    assign n_span      = WORD_W'(i_req.range_end) - WORD_W'(i_req.range_start) + 1'b1;

    assign n_rd_addr = (r_idx == LAST) ? '0 : r_idx + 1'b1;

    // fold the new carry into the low word with end-around correction
    assign n_carry_hi = mul_prod[WORD_W +: CARRY_W];
    assign n_fold     = {1'b0, mul_prod[WORD_W-1:0]} + (WORD_W+1)'(n_carry_hi);
    assign n_x        = n_fold[WORD_W] ? n_fold[WORD_W-1:0] + 1'b1 : n_fold[WORD_W-1:0];
    assign n_carry    = n_fold[WORD_W] ? n_carry_hi + 1'b1 : n_carry_hi;
    assign n_w        = CMWC_BASE - n_x;

    assign n_wr_en   = fill_stat.wr_en || (r_state == S_FIX);
    assign n_wr_addr = fill_stat.busy ? fill_addr : r_idx;
    assign n_wr_data = fill_stat.busy ? fill_data : n_w;

    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_mem[n_wr_addr] <= n_wr_data;
        end
        r_rd_data <= r_mem[n_rd_addr];
    end

    assign n_slot_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= LAST;
            r_carry     <= CARRY_INIT;
            r_mul_start <= 1'b0;
            r_mod_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_start <= n_accept && !n_bad;
            r_mod_start <= (r_state == S_FIX) && !r_full;
            // drop the beat once taken unless a new one replaces it
            if (o_res.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_idx   <= LAST;
                r_carry <= CARRY_INIT;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_start <= WORD_W'(i_req.range_start);
                        r_span  <= n_span;
                        r_full  <= (n_span == '0);
                        r_err   <= n_bad;
                        if (n_bad) begin
                            r_state <= S_OUT;
                        end else begin
                            // table word for the advanced index is read at this edge
                            r_idx   <= n_rd_addr;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    if (mul_stat.done) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_carry <= n_carry;
                    r_word  <= n_w;
                    if (r_full) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (mod_stat.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the result register is free
                    if (n_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_err   <= r_err;
                        priority if (r_err) begin
                            r_out_value <= '0;
                        end else if (r_full) begin
                            r_out_value <= r_word;
                        end else begin
                            r_out_value <= mod_rem + r_start;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.value       = r_out_value;
    assign o_res.range_error = r_out_err;

endmodule
`default_nettype wire

// ===== bench/tb_cmwc_random_range_generator_top.sv =====
// Self-checking bench for the lag-8 CMWC range generator: directed ranges, then random ranges
// under several seeds, with random stalls on request and result streams.
// Depends on crrg_pkg, crrg_if and cmwc_random_range_generator_top.
`timescale 1ns / 100ps
module tb_cmwc_random_range_generator_top;

    localparam int          W           = crrg_pkg::WORD_W;
    localparam int          LAG_DEPTH   = 8;
    localparam int          CYCLE_LIMIT = 1_500_000;
    localparam logic [63:0] CMWC_FACTOR = 64'd716514398;
    localparam logic [W-1:0] WORD_BASE  = 32'hffff_fffe;
    localparam logic [W-1:0] CARRY_SEED = 32'd362436;
    localparam logic [W-1:0] ZERO_SUB   = 32'd12345;
    localparam logic [W-1:0] RESET_SEED = 32'd987654321;
    localparam logic [W-1:0] RANGE_MIN  = 32'h8000_0000;
    localparam logic [W-1:0] RANGE_MAX  = 32'h7fff_ffff;

    typedef struct packed {
        logic [W-1:0] value;
        logic         range_error;
    } t_range_result;

    typedef struct packed {
        logic [W-1:0] lo;
        logic [W-1:0] hi;
        logic         fixed_on;
        logic [W-1:0] fixed_value;
        logic         fixed_err;
    } t_range_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [W-1:0] i_cfg_wdata;

    crrg_in_if  req_if ();
    crrg_out_if res_if ();

    cmwc_random_range_generator_top #(.LAG(LAG_DEPTH)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    // Generator state mirrored by the bench
    logic [W-1:0]  lag_words [LAG_DEPTH];
    logic [W-1:0]  cmwc_carry;
    int            lag_pos;

    t_range_result expected_results [$];
    t_range_row    directed_rows [$];

    // Typed-in expectation travels with the request beat
    logic          fixed_on;
    logic [W-1:0]  fixed_value;
    logic          fixed_err;

    bit            steady_run;
    int            ready_hold;
    int            cycle_count;
    int            mismatches;
    int            accepted_count;
    int            rejected_count;
    int            full_span_count;
    int            seeds_used;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic void reload_lag_table(input logic [W-1:0] seed);
        logic [W-1:0] j;
        int           k;
        j = (seed == '0) ? ZERO_SUB : seed;
        for (k = 0; k < LAG_DEPTH; k++) begin
            j = j ^ (j << 13);
            j = j ^ (j >> 17);
            j = j ^ (j << 5);
            lag_words[k] = j;
        end
        cmwc_carry = CARRY_SEED;
        lag_pos    = LAG_DEPTH - 1;
    endfunction

    function automatic t_range_result predict_range(input logic [W-1:0] lo,
                                                    input logic [W-1:0] hi);
        t_range_result r;
        logic [63:0]   prod;
        logic [W-1:0]  x;
        logic [W-1:0]  w;
        logic [W-1:0]  span;
        if ($signed(hi) <= $signed(lo)) begin
            r.value       = '0;
            r.range_error = 1'b1;
            return r;
        end
        span    = hi - lo + 32'd1;
        lag_pos = (lag_pos == LAG_DEPTH - 1) ? 0 : lag_pos + 1;
        prod    = CMWC_FACTOR * {32'd0, lag_words[lag_pos]} + {32'd0, cmwc_carry};
        cmwc_carry = prod[63:32];
        x = prod[31:0] + cmwc_carry;
        // end-around fold of the carry
        if (x < cmwc_carry) begin
            x          = x + 32'd1;
            cmwc_carry = cmwc_carry + 32'd1;
        end
        w = WORD_BASE - x;
        lag_words[lag_pos] = w;
        r.value       = (span == '0) ? w : (w % span) + lo;
        r.range_error = 1'b0;
        return r;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        if (steady_run)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 120);
    endfunction

    function automatic void pick_range(output logic [W-1:0] lo, output logic [W-1:0] hi);
        int unsigned        mode;
        logic [W-1:0]       len;
        logic [W-1:0]       tmp;
        logic signed [33:0] top;
        mode = $urandom_range(0, 19);
        lo   = $urandom;
        hi   = $urandom;
        if (mode < 14) begin
            if (mode < 9)
                len = $urandom_range(1, 1000);
            else if (mode < 12)
                len = (32'd1 << $urandom_range(1, 31)) - 32'd1;
            else
                len = $urandom;
            // keep the upper bound from wrapping past the top
            top = $signed({{2{lo[W-1]}}, lo}) + $signed({2'b00, len});
            if (top > $signed({2'b00, RANGE_MAX}))
                lo = RANGE_MAX - len;
            hi = lo + len;
        end else if (mode < 16) begin
            // leave both bounds fully random
        end else if (mode < 18) begin
            if ($signed(hi) > $signed(lo)) begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
        end else begin
            lo = RANGE_MIN;
            hi = RANGE_MAX;
        end
    endfunction

    task automatic add_row(input logic [W-1:0] lo, input logic [W-1:0] hi,
                           input logic on, input logic [W-1:0] value, input logic err);
        directed_rows.push_back('{lo, hi, on, value, err});
    endtask

    task automatic send_range(input t_range_row row);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.range_start <= row.lo;
        req_if.range_end   <= row.hi;
        fixed_on           <= row.fixed_on;
        fixed_value        <= row.fixed_value;
        fixed_err          <= row.fixed_err;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        t_range_row row;
        int         n;
        row = '0;
        for (n = 0; n < count; n++) begin
            pick_range(row.lo, row.hi);
            send_range(row);
        end
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [W-1:0] seed);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= seed;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        reload_lag_table(seed);
        seeds_used++;
    endtask

    // Predict on every accepted request beat
    always @(posedge i_clk) begin : request_monitor
        t_range_result want;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            want = predict_range(req_if.range_start, req_if.range_end);
            if (fixed_on)
                want = '{fixed_value, fixed_err};
            expected_results.push_back(want);
            accepted_count++;
            if (want.range_error)
                rejected_count++;
            if (req_if.range_start == RANGE_MIN && req_if.range_end == RANGE_MAX)
                full_span_count++;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_range_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat: value %0d, error %0b",
                         $time, $signed(res_if.value), res_if.range_error);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (res_if.value !== want.value) begin
                    $display("%0t: value mismatch: expected %0d, actual %0d",
                             $time, $signed(want.value), $signed(res_if.value));
                    mismatches++;
                end
                if (res_if.range_error !== want.range_error) begin
                    $display("%0t: range_error mismatch: expected %0b, actual %0b",
                             $time, want.range_error, res_if.range_error);
                    mismatches++;
                end
            end
        end
    end

    // Result side: hold ready high in runs, drop it for short and occasionally long stalls
    always @(posedge i_clk) begin : result_ready
        int unsigned r;
        if (steady_run) begin
            res_if.ready <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                res_if.ready <= 1'b1;
                ready_hold   <= $urandom_range(0, 6);
            end else if (r < 94) begin
                res_if.ready <= 1'b0;
                ready_hold   <= $urandom_range(0, 4);
            end else begin
                res_if.ready <= 1'b0;
                ready_hold   <= $urandom_range(20, 120);
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d results outstanding",
                 $time, cycle_count, expected_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [W-1:0] seed_list [6];
        int           p;

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        req_if.valid       = 1'b0;
        req_if.range_start = '0;
        req_if.range_end   = '0;
        res_if.ready       = 1'b0;
        fixed_on           = 1'b0;
        fixed_value        = '0;
        fixed_err          = 1'b0;
        steady_run         = 1'b0;
        ready_hold         = 0;
        mismatches         = 0;
        accepted_count     = 0;
        rejected_count     = 0;
        full_span_count    = 0;
        seeds_used         = 1;
        reload_lag_table(RESET_SEED);

        add_row(32'd0,               32'd10,              1'b0, 32'd0, 1'b0);
        add_row(RANGE_MIN,           RANGE_MAX,           1'b0, 32'd0, 1'b0);
        add_row(32'd5,               32'd5,               1'b1, 32'd0, 1'b1);
        add_row(32'd10,              -32'sd10,            1'b1, 32'd0, 1'b1);
        add_row(RANGE_MAX,           RANGE_MIN,           1'b1, 32'd0, 1'b1);
        add_row(RANGE_MIN,           RANGE_MIN,           1'b1, 32'd0, 1'b1);
        add_row(RANGE_MAX,           RANGE_MAX,           1'b1, 32'd0, 1'b1);
        add_row(RANGE_MIN,           RANGE_MIN + 32'd1,   1'b0, 32'd0, 1'b0);
        add_row(RANGE_MAX - 32'd1,   RANGE_MAX,           1'b0, 32'd0, 1'b0);
        add_row(RANGE_MIN,           RANGE_MAX - 32'd1,   1'b0, 32'd0, 1'b0);
        add_row(RANGE_MIN + 32'd1,   RANGE_MAX,           1'b0, 32'd0, 1'b0);
        add_row(-32'sd1,             32'd0,               1'b0, 32'd0, 1'b0);
        add_row(32'd0,               RANGE_MAX,           1'b0, 32'd0, 1'b0);
        add_row(RANGE_MIN,           32'd0,               1'b0, 32'd0, 1'b0);
        add_row(-32'sd100,           32'd100,             1'b0, 32'd0, 1'b0);
        add_row(32'd0,               32'd1,               1'b0, 32'd0, 1'b0);
        add_row(-32'sd1000,          -32'sd1,             1'b0, 32'd0, 1'b0);
        add_row(32'hffff_ffff,       32'hffff_fffe,       1'b1, 32'd0, 1'b1);
        add_row(RANGE_MIN,           RANGE_MAX,           1'b0, 32'd0, 1'b0);
        add_row(32'h5555_5555,       32'h6aaa_aaaa,       1'b0, 32'd0, 1'b0);
        add_row(32'haaaa_aaaa,       32'h1555_5555,       1'b0, 32'd0, 1'b0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset seed: directed rows wrap the lag index, then random traffic
        for (p = 0; p < directed_rows.size(); p++)
            send_range(directed_rows[p]);
        send_random(200);

        seed_list = '{32'd0, 32'hffff_ffff, 32'd1, 32'h8000_0000, $urandom, $urandom};
        for (p = 0; p < 6; p++) begin
            req_if.valid <= 1'b0;
            wait_drained();
            write_seed(seed_list[p]);
            // one phase runs back to back with no idling on either side
            steady_run = (p == 1);
            send_random(175);
        end

        req_if.valid <= 1'b0;
        steady_run = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Checked %0d range requests under %0d seeds (%0d rejected, %0d full span),",
                 accepted_count, seeds_used, rejected_count, full_span_count);
        $display("with random stalls on both streams and one back-to-back phase.");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
